// ===== src/lmsr_pkg.sv =====
// Shared types, codes and tables for the LED matrix status renderer.
// No dependencies; imported by every module of the block.
package lmsr_pkg;

    // Action codes carried in the input tuser field.
    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_SET    = 2'd1;
    localparam logic [1:0] ACT_REPORT = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_BOOT  = 3'd0;
    localparam logic [2:0] ST_CALIB = 3'd1;
    localparam logic [2:0] ST_READY = 3'd2;
    localparam logic [2:0] ST_NOSIG = 3'd3;
    localparam logic [2:0] ST_ERROR = 3'd4;

    // Frame geometry.
    localparam int PIX_W = 6;
    localparam logic [PIX_W-1:0] PIX_LAST = 6'd63;
    localparam logic [2:0] EDGE = 3'd7;

    // Default depth of the frame request queue.
    localparam int FIFO_DEPTH_DEF = 2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // One frame request from the front end to the pixel engine.
    typedef struct packed {
        logic [2:0] status;
        logic       wifi;
        logic       bbox;
        logic [1:0] rotation;
    } frame_desc_t;

    localparam rgb_t WIFI_RGB = '{red: 8'd0,  green: 8'd8, blue: 8'd32};
    localparam rgb_t BBOX_RGB = '{red: 8'd18, green: 8'd0, blue: 8'd28};

    // Glyph color for a status code; codes above error draw as error.
    function automatic rgb_t status_rgb(input logic [2:0] st);
        rgb_t c;
        begin
            unique case (st)
                ST_BOOT:  c = '{red: 8'd0,  green: 8'd28, blue: 8'd32};
                ST_CALIB: c = '{red: 8'd30, green: 8'd18, blue: 8'd0};
                ST_READY: c = '{red: 8'd0,  green: 8'd32, blue: 8'd5};
                ST_NOSIG: c = '{red: 8'd36, green: 8'd0,  blue: 8'd0};
                default:  c = '{red: 8'd36, green: 8'd0,  blue: 8'd18};
            endcase
            return c;
        end
    endfunction

    // Glyph row for a status code; bit x marks logical column x.
    function automatic logic [7:0] glyph_row(input logic [2:0] st, input logic [2:0] y);
        logic [7:0] hg;
        logic [7:0] ck;
        logic [7:0] cr;
        begin
            unique case (y)
                3'd0:    begin hg = 8'h00; ck = 8'h00; cr = 8'h00; end
                3'd1:    begin hg = 8'h3C; ck = 8'h00; cr = 8'h42; end
                3'd2:    begin hg = 8'h24; ck = 8'h40; cr = 8'h24; end
                3'd3:    begin hg = 8'h18; ck = 8'h40; cr = 8'h18; end
                3'd4:    begin hg = 8'h18; ck = 8'h22; cr = 8'h18; end
                3'd5:    begin hg = 8'h24; ck = 8'h14; cr = 8'h24; end
                3'd6:    begin hg = 8'h3C; ck = 8'h08; cr = 8'h42; end
                default: begin hg = 8'h00; ck = 8'h00; cr = 8'h00; end
            endcase
            case (st)
                ST_BOOT, ST_CALIB: return hg;
                ST_READY:          return ck;
                default:           return cr;
            endcase
        end
    endfunction

endpackage

// ===== src/lmsr_fifo.sv =====
// Small register queue of frame requests between front end and pixel engine.
// Depends on lmsr_pkg for the frame request type.
module lmsr_fifo #(
    parameter int DEPTH = lmsr_pkg::FIFO_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lmsr_pkg::frame_desc_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output lmsr_pkg::frame_desc_t head
);
    import lmsr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    frame_desc_t   mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == CNT_FULL);
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |-> !push)
        else $error("frame queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("frame queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("frame queue count out of range");

endmodule

// ===== src/lmsr_front.sv =====
// Event front end: holds the status state and rotation register, classifies
// each event transfer and queues a frame request when one must be drawn.
// Depends on lmsr_pkg.
module lmsr_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_wdata,
    input  logic                  ev_valid,
    output logic                  ev_ready,
    input  logic [1:0]            ev_action,
    input  logic [2:0]            ev_new_status,
    input  logic                  ev_receiver_signal,
    input  logic                  ev_wifi_enabled,
    input  logic                  ev_blackbox_ready,
    output logic                  push,
    output lmsr_pkg::frame_desc_t push_data,
    input  logic                  q_full
);
    import lmsr_pkg::*;

    logic [1:0] rotation_reg;
    logic [2:0] status_reg, status_next;
    logic       wifi_reg, wifi_next;
    logic       bbox_reg, bbox_next;
    logic       started_reg, started_next;
    logic       dirty_reg, dirty_next;
    logic       upd;
    logic       render;
    logic       take;
    logic [2:0] cand;

    assign ev_ready = !q_full;
    assign take     = ev_valid && ev_ready;
    assign cand     = ev_receiver_signal ? ST_READY : ST_NOSIG;

    // Event rules: work out the updated state and whether it draws a frame.
    always_comb
    begin
        status_next  = status_reg;
        wifi_next    = wifi_reg;
        bbox_next    = bbox_reg;
        started_next = started_reg;
        dirty_next   = dirty_reg;
        upd          = 1'b0;
        unique case (ev_action)
            ACT_START:
            begin
                started_next = 1'b1;
                status_next  = ST_BOOT;
                dirty_next   = 1'b1;
                upd          = 1'b1;
            end
            ACT_SET:
            begin
                if (ev_new_status <= ST_ERROR &&
                    !(ev_new_status == status_reg && !dirty_reg))
                begin
                    status_next = ev_new_status;
                    dirty_next  = 1'b1;
                    upd         = 1'b1;
                end
            end
            ACT_REPORT:
            begin
                if (status_reg != ST_ERROR &&
                    !(cand == status_reg && ev_wifi_enabled == wifi_reg &&
                      ev_blackbox_ready == bbox_reg))
                begin
                    status_next = cand;
                    wifi_next   = ev_wifi_enabled;
                    bbox_next   = ev_blackbox_ready;
                    dirty_next  = 1'b1;
                    upd         = 1'b1;
                end
            end
            default:
            begin
                upd = 1'b0;
            end
        endcase
        render = upd && started_next;
        if (render)
        begin
            dirty_next = 1'b0;
        end
    end

    assign push = take && render;
    assign push_data = '{status: status_next, wifi: wifi_next, bbox: bbox_next,
                         rotation: rotation_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg <= '0;
            status_reg   <= ST_BOOT;
            wifi_reg     <= 1'b0;
            bbox_reg     <= 1'b0;
            started_reg  <= 1'b0;
            dirty_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                rotation_reg <= cfg_wdata;
            end
            if (take)
            begin
                status_reg  <= status_next;
                wifi_reg    <= wifi_next;
                bbox_reg    <= bbox_next;
                started_reg <= started_next;
                dirty_reg   <= dirty_next;
            end
        end
    end

    a_push_clears_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !dirty_reg && started_reg)
        else $error("frame queued but state not left started and clean");
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        take && status_reg == ST_ERROR && ev_action == ACT_REPORT |=> status_reg == ST_ERROR)
        else $error("report changed the error status");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg <= ST_ERROR)
        else $error("stored status out of range");

endmodule

// ===== src/lmsr_back.sv =====
// Pixel engine: walks the 64 physical pixels of a queued frame request and
// drives the result stream through an output register. Depends on lmsr_pkg.
module lmsr_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_not_empty,
    input  lmsr_pkg::frame_desc_t q_head,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [5:0]            out_pixel_index,
    output lmsr_pkg::rgb_t        out_rgb,
    output logic                  out_last
);
    import lmsr_pkg::*;

    frame_desc_t      desc_reg;
    logic             busy_reg;
    logic [PIX_W-1:0] cnt_reg;
    logic             valid_reg;
    logic [PIX_W-1:0] idx_reg;
    rgb_t             rgb_reg;
    logic             last_reg;
    logic             adv;
    logic [2:0]       px, py, lx, ly;
    logic [7:0]       row;
    rgb_t             pix_rgb;

    assign q_pop = !busy_reg && q_not_empty;
    assign adv   = busy_reg && (!valid_reg || out_ready);
    assign px    = cnt_reg[2:0];
    assign py    = cnt_reg[5:3];

    // Map the physical pixel back to its logical coordinate.
    always_comb
    begin
        unique case (desc_reg.rotation)
            2'd1:    begin lx = py;        ly = EDGE - px; end
            2'd2:    begin lx = EDGE - px; ly = EDGE - py; end
            2'd3:    begin lx = EDGE - py; ly = px;        end
            default: begin lx = px;        ly = py;        end
        endcase
    end

    // Pixel color: corner marks over the glyph, black elsewhere.
    always_comb
    begin
        row = glyph_row(desc_reg.status, ly);
        pix_rgb = '0;
        if (row[lx])
        begin
            pix_rgb = status_rgb(desc_reg.status);
        end
        if (desc_reg.wifi && lx == 3'd0 && ly == EDGE)
        begin
            pix_rgb = WIFI_RGB;
        end
        if (desc_reg.bbox && lx == EDGE && ly == EDGE)
        begin
            pix_rgb = BBOX_RGB;
        end
    end

    // Frame sequencing and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (adv)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == PIX_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (adv)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            desc_reg <= q_head;
        end
        if (adv)
        begin
            idx_reg  <= cnt_reg;
            rgb_reg  <= pix_rgb;
            last_reg <= (cnt_reg == PIX_LAST);
        end
    end

    assign out_valid       = valid_reg;
    assign out_pixel_index = idx_reg;
    assign out_rgb         = rgb_reg;
    assign out_last        = last_reg;

    a_frame_ends: assert property (@(posedge clk) disable iff (!rst_n)
        adv && cnt_reg == PIX_LAST |=> !busy_reg)
        else $error("pixel engine ran past the last pixel");
    a_last_on_63: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && last_reg |-> idx_reg == PIX_LAST)
        else $error("end of frame flagged on wrong pixel");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !busy_reg && !adv)
        else $error("new frame taken while a frame is in progress");

endmodule

// ===== src/led_matrix_status_renderer_unit.sv =====
// Top level of the LED matrix status renderer.
// Depends on lmsr_pkg, lmsr_front, lmsr_fifo and lmsr_back.
//
// Events enter on the s_axis stream; each one that updates the state while the
// display is started produces a full 8x8 frame on m_axis: 64 transfers in
// physical pixel order, one per cycle while m_axis_tready is high, tlast on
// pixel 63. The pixel engine takes the next frame request only after the last
// pixel of the current frame has entered its output register; an event that
// draws nothing queues no request. The front end takes events as long as the
// frame request queue (FIFO_DEPTH entries) has room, so events keep flowing
// while a frame is still being streamed out. A rotation write applies to frames
// requested afterwards and must be made while the block is idle.
module led_matrix_status_renderer_unit #(
    parameter int FIFO_DEPTH = lmsr_pkg::FIFO_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Rotation register write.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    // Event stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] new_status, [3] receiver_signal, [4] wifi_enabled,
    // [5] blackbox_ready, [7:6] zero
    input  logic [7:0]  s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    // Pixel stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] pixel_index, [13:6] red, [21:14] green, [29:22] blue, [31:30] zero
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import lmsr_pkg::*;

    logic        push;
    frame_desc_t push_data;
    logic        q_full;
    logic        q_pop;
    logic        q_not_empty;
    frame_desc_t q_head;
    logic [5:0]  pixel_index;
    rgb_t        pix_rgb;

    lmsr_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .ev_valid           (s_axis_tvalid),
        .ev_ready           (s_axis_tready),
        .ev_action          (s_axis_tuser),
        .ev_new_status      (s_axis_tdata[2:0]),
        .ev_receiver_signal (s_axis_tdata[3]),
        .ev_wifi_enabled    (s_axis_tdata[4]),
        .ev_blackbox_ready  (s_axis_tdata[5]),
        .push               (push),
        .push_data          (push_data),
        .q_full             (q_full)
    );

    lmsr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    lmsr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_not_empty     (q_not_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_pixel_index (pixel_index),
        .out_rgb         (pix_rgb),
        .out_last        (m_axis_tlast)
    );

    // Pack the pixel fields, lowest field first.
    assign m_axis_tdata = {2'b00, pix_rgb.blue, pix_rgb.green, pix_rgb.red, pixel_index};

endmodule
